// File: design/mrf_pkg.sv
package mrf_pkg;

  localparam int unsigned FrameLen  = 8;
  localparam int unsigned CrcSpan   = 6;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam int unsigned ReqWidth  = 48;
  localparam int unsigned IdxWidth  = $clog2(FrameLen);

  localparam logic [IdxWidth-1:0] IdxCrcLow  = IdxWidth'(CrcSpan);
  localparam logic [IdxWidth-1:0] IdxCrcHigh = IdxWidth'(CrcSpan + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  function automatic logic [15:0] crc_table_entry(logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
    logic [7:0] idx;
    idx = crc[7:0] ^ data;
    return crc_table_entry(idx) ^ {8'h00, crc[15:8]};
  endfunction

endpackage

// File: design/mrf_frame_gen.sv
module mrf_frame_gen
  import mrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [ReqWidth-1:0] req_data_i,
  output logic                beat_valid_o,
  input  logic                beat_ready_i,
  output frame_beat_t         beat_o
);

  logic                busy_q, busy_d;
  logic [IdxWidth-1:0] idx_q, idx_d;
  logic [ReqWidth-1:0] frame_q, frame_d;
  logic [15:0]         crc_q, crc_d;
  logic                fire;
  logic                take;
  logic [7:0]          cur_byte;

  assign fire        = busy_q && beat_ready_i;
  assign req_ready_o = !busy_q || (fire && (idx_q == IdxCrcHigh));
  assign take        = req_valid_i && req_ready_o;

  always_comb begin
    case (idx_q)
      IdxCrcLow:  cur_byte = crc_q[7:0];
      IdxCrcHigh: cur_byte = crc_q[15:8];
      default:    cur_byte = frame_q[7:0];
    endcase
  end

  assign beat_valid_o = busy_q;
  assign beat_o.data  = cur_byte;
  assign beat_o.last  = (idx_q == IdxCrcHigh);

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    frame_d = frame_q;
    crc_d   = crc_q;
    if (fire) begin
      idx_d   = idx_q + IdxWidth'(1);
      frame_d = frame_q >> 8;
      if (idx_q < IdxCrcLow) begin
        crc_d = crc_update(crc_q, cur_byte);
      end
      if (idx_q == IdxCrcHigh) begin
        busy_d = 1'b0;
      end
    end
    if (take) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      crc_d   = CrcInit;
      frame_d = {req_data_i[39:32], req_data_i[47:40], req_data_i[23:16],
                 req_data_i[31:24], req_data_i[15:8], req_data_i[7:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    crc_q   <= crc_d;
  end

endmodule

// File: design/mrf_out_stage.sv
module mrf_out_stage
  import mrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_valid_i,
  output logic        beat_ready_o,
  input  frame_beat_t beat_i,
  output logic        valid_o,
  input  logic        ready_i,
  output frame_beat_t beat_o
);

  logic        valid_q, valid_d;
  frame_beat_t beat_q;

  assign beat_ready_o = !valid_q || ready_i;
  assign valid_d      = beat_valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_valid_i && beat_ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// File: design/modbus_read_request_framer.sv
// Channel   Direction  Transaction
// s_axis    in         one read request: tdata = slave_address, function_code,
//                      register_address, register_count (48 bits)
// m_axis    out        one frame byte: tdata = frame_byte, tlast = last_byte
//
// Each request gives eight output transactions, one per cycle at most; the
// next request is taken in the cycle its predecessor's CRC high byte moves to
// the output register. The CRC is updated by one table lookup per data byte.
// Reset clears the sequencer and the output register; no state is kept between
// requests. A stall on m_axis holds the output register and the sequencer.
module modbus_read_request_framer
  import mrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] slave_address, [15:8] function_code, [31:16] register_address,
  // [47:32] register_count
  input  logic [ReqWidth-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] frame_byte
  output logic [7:0]          m_axis_tdata,
  output logic                m_axis_tlast
);

  logic        beat_valid;
  logic        beat_ready;
  frame_beat_t beat;
  frame_beat_t out_beat;

  mrf_frame_gen u_frame_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .beat_valid_o (beat_valid),
    .beat_ready_i (beat_ready),
    .beat_o       (beat)
  );

  mrf_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_ready_o (beat_ready),
    .beat_i       (beat),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .beat_o       (out_beat)
  );

  assign m_axis_tdata = out_beat.data;
  assign m_axis_tlast = out_beat.last;

endmodule

// File: tb/modbus_read_request_framer_tb.sv
module modbus_read_request_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrf_pkg::*;

  class frame_scoreboard;
    frame_beat_t expected_beats[$];
    int unsigned mismatches;
    int unsigned bytes_checked;

    function new();
      mismatches = 0;
      bytes_checked = 0;
    endfunction

    function void note_request(logic [7:0] slave_addr, logic [7:0] func_code,
                               logic [15:0] start_reg, logic [15:0] reg_count);
      logic [7:0]  frame [FrameLen];
      logic [15:0] crc;
      frame = '{slave_addr, func_code, start_reg[15:8], start_reg[7:0],
                reg_count[15:8], reg_count[7:0], 8'h00, 8'h00};
      crc = CrcInit;
      // The CRC is worked out bit by bit, independently of the table form.
      for (int i = 0; i < CrcSpan; i++) begin
        crc ^= {8'h00, frame[i]};
        for (int k = 0; k < 8; k++) begin
          crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
        end
      end
      frame[CrcSpan]     = crc[7:0];
      frame[CrcSpan + 1] = crc[15:8];
      for (int i = 0; i < FrameLen; i++) begin
        expected_beats.push_back('{data: frame[i], last: (i == FrameLen - 1)});
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_beat_t want;
      bytes_checked++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected frame byte %02h last %0b", data, last);
        end
        return;
      end
      want = expected_beats.pop_front();
      if (want.data !== data || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("frame byte %0d: expected %02h last %0b, got %02h last %0b",
                   bytes_checked - 1, want.data, want.last, data, last);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ReqWidth-1:0] s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;

  frame_scoreboard frame_sb = new();

  int unsigned requests_sent = 0;
  bit          tx_calm = 1'b0;
  bit          tx_busy = 1'b1;
  bit          rx_calm = 1'b0;
  bit          rx_busy = 1'b1;
  int          rx_window = 0;
  int          rx_gap_left = 0;
  int          rx_hold_left = 0;

  modbus_read_request_framer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      frame_sb.check_byte(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_window == 0) begin
        rx_window = 64;
        rx_busy = $urandom_range(0, 2) != 0;
      end
      rx_window--;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        m_axis_tready <= 1'b0;
      end else if (!rx_calm && rx_busy && $urandom_range(0, 5) == 0) begin
        rx_gap_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [7:0] slave_addr, input logic [7:0] func_code,
                              input logic [15:0] start_reg, input logic [15:0] reg_count,
                              input bit may_idle);
    int gap;
    if (may_idle && !tx_calm && tx_busy && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {16'($urandom), 32'($urandom)};
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {reg_count, start_reg, func_code, slave_addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frame_sb.note_request(slave_addr, func_code, start_reg, reg_count);
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (frame_sb.expected_beats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_value(logic [15:0] max_val);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return max_val;
      default: return 16'($urandom_range(0, max_val));
    endcase
  endfunction

  task automatic send_random(input bit may_idle);
    logic [7:0] func_code;
    func_code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(3, 4))
                                             : 8'(pick_value(16'h00FF));
    send_request(8'(pick_value(16'h00FF)), func_code, pick_value(16'hFFFF),
                 pick_value(16'hFFFF), may_idle);
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rst_ni        <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1);
    send_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(8'h01, 8'h03, 16'h0000, 16'h0001, 1'b1);
    send_request(8'h11, 8'h03, 16'h006B, 16'h0003, 1'b1);
    send_request(8'h01, 8'h01, 16'h0013, 16'h0025, 1'b1);
    send_request(8'h02, 8'h02, 16'h00C4, 16'h0016, 1'b1);
    send_request(8'h0A, 8'h04, 16'h0008, 16'h007D, 1'b1);
    send_request(8'hAA, 8'h55, 16'hAAAA, 16'h5555, 1'b1);
    send_request(8'h55, 8'hAA, 16'h5555, 16'hAAAA, 1'b1);
    send_request(8'h80, 8'h80, 16'h8000, 16'h8000, 1'b1);
    send_request(8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF, 1'b1);
    send_request(8'hFE, 8'h01, 16'h0001, 16'hFFFE, 1'b1);
    send_request(8'hF7, 8'h10, 16'hFFFF, 16'h0000, 1'b1);
    wait_drained();

    // The output is held off long enough for the framer to back up its input.
    rx_hold_left = 400;
    for (int i = 0; i < 12; i++) send_random(1'b0);
    wait_drained();

    for (int i = 0; i < 500; i++) begin
      if (i % 40 == 0) begin
        tx_busy = $urandom_range(0, 2) != 0;
      end
      if (i == 250) begin
        wait_drained();
      end
      if (i == 420) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      send_random(1'b1);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("%0d read requests framed, %0d frame bytes checked against the predicted CRC.",
             requests_sent, frame_sb.bytes_checked);
    $display("Run included a long output stall, a full drain pause and random idling.");
    if (frame_sb.mismatches == 0 && frame_sb.expected_beats.size() == 0) begin
      $display("modbus_read_request_framer_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d frame bytes never arrived",
               frame_sb.mismatches, frame_sb.expected_beats.size());
      $display("modbus_read_request_framer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timed out with %0d frame bytes outstanding", frame_sb.expected_beats.size());
    $display("modbus_read_request_framer_tb: FAIL");
    $finish;
  end

endmodule

// File: sim.f
design/mrf_pkg.sv
design/mrf_frame_gen.sv
design/mrf_out_stage.sv
design/modbus_read_request_framer.sv
tb/modbus_read_request_framer_tb.sv
